>>> hw/rtl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned CodeWidth = 3;

    typedef enum logic [CodeWidth-1:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_CLICK   = 3'd2,
        EV_LSTART  = 3'd3,
        EV_LFINISH = 3'd4,
        EV_LINTR   = 3'd5
    } t_event_code;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_CLICK    = 2'd1,
        CFG_LONG     = 2'd2,
        CFG_ID       = 2'd3
    } t_cfg_index;

    localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
    localparam logic [CfgWidth-1:0] ClickReset    = 16'd500;
    localparam logic [CfgWidth-1:0] LongReset     = 16'd2000;
    localparam logic [CfgWidth-1:0] IdReset       = 16'd0;

endpackage

>>> hw/rtl/button_debounce_press_classifier_core.sv
`timescale 1ns / 1ps

// Button debouncer with press / click / long-press classification.
// Input stream: one poll per transaction, tdata = {now_ms[31:0], raw_level}.
// Output stream: one event per transaction, tdata = {stable_level, event_id,
// event_code}, tlast marks the final event of a poll. A poll yields zero,
// one or two events; a quiet poll yields none.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_addr
// (0 debounce_ms, 1 click_threshold_ms, 2 long_press_ms, 3 button_id);
// write only while the block is idle.
// Path: an accepted poll is captured in the input register, evaluated from
// there, and its events are registered in the output register. Throughput:
// one poll per cycle while each poll yields at most one event and the receiver
// takes every event; a poll with two events holds the output register until
// both have left (one event leaves per cycle while the receiver is ready).
// The poll input register is free again as soon as the output register can
// take its events, so a poll is accepted while a finished event waits.
// Receiver stall: events are held in the output register; the input side
// stalls once the input register is full and cannot advance.
// Reset (synchronous, active low): debounce state, timestamps and long-press
// flags clear, config registers return to 50 / 500 / 2000 / 0.
module button_debounce_press_classifier_core
    import bdpc_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [CfgWidth-1:0] i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [39:0]         i_s_tdata,   // [0] raw_level, [32:1] now_ms, [39:33] zero
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [23:0]         o_m_tdata,   // [2:0] event_code, [18:3] event_id,
                                             // [19] stable_level, [23:20] zero
    output logic                o_m_tlast
);

    localparam int unsigned InBits = (TIME_BITS < 32) ? TIME_BITS : 32;

    logic [CfgWidth-1:0]        r_debounce, r_click, r_long;
    logic signed [CfgWidth-1:0] r_id;

    logic                 r_in_valid;
    logic                 r_in_raw;
    logic [TIME_BITS-1:0] r_in_now;

    logic                 r_noisy, r_deb, r_long_ongoing, r_long_done;
    logic [TIME_BITS-1:0] r_change_time, r_press_time;

    logic                 r_out_valid, r_two, r_sel, r_out_level;
    t_event_code          r_code0, r_code1;
    logic signed [CfgWidth-1:0] r_out_id;

    logic                 n_noisy, n_deb, n_long_ongoing, n_long_done, changed;
    logic [TIME_BITS-1:0] n_change_time, n_press_time, settle, held;
    logic [1:0]           n_count;
    t_event_code          n_code0, n_code1;
    logic                 out_free, advance;

    assign out_free   = !r_out_valid || (i_m_tready && o_m_tlast);
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_comb begin
        n_noisy        = r_in_raw;
        n_change_time  = (r_in_raw != r_noisy) ? r_in_now : r_change_time;
        settle         = r_in_now - n_change_time;
        held           = r_in_now - r_press_time;
        changed        = (settle > TIME_BITS'(r_debounce)) && (n_noisy != r_deb);
        n_deb          = changed ? n_noisy : r_deb;
        n_press_time   = r_press_time;
        n_long_ongoing = r_long_ongoing;
        n_long_done    = r_long_done;
        n_count        = 2'd0;
        n_code0        = EV_PRESS;
        n_code1        = EV_CLICK;
        if (changed) begin
            if (n_deb) begin
                n_press_time = r_in_now;
                n_code0      = EV_PRESS;
                n_count      = 2'd1;
            end else begin
                n_code0 = EV_RELEASE;
                if (r_long_done) begin
                    n_long_done = 1'b0;
                    n_count     = 2'd1;
                end else if (r_long_ongoing) begin
                    n_long_ongoing = 1'b0;
                    n_code1        = EV_LINTR;
                    n_count        = 2'd2;
                end else begin
                    n_code1 = EV_CLICK;
                    n_count = 2'd2;
                end
            end
        end else if (r_deb && !r_long_done) begin
            if (r_long_ongoing) begin
                if (held > TIME_BITS'(r_long)) begin
                    n_long_ongoing = 1'b0;
                    n_long_done    = 1'b1;
                    n_code0        = EV_LFINISH;
                    n_count        = 2'd1;
                end
            end else if (held > TIME_BITS'(r_click)) begin
                n_long_ongoing = 1'b1;
                n_code0        = EV_LSTART;
                n_count        = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce     <= DebounceReset;
            r_click        <= ClickReset;
            r_long         <= LongReset;
            r_id           <= IdReset;
            r_in_valid     <= 1'b0;
            r_noisy        <= 1'b0;
            r_deb          <= 1'b0;
            r_change_time  <= '0;
            r_press_time   <= '0;
            r_long_ongoing <= 1'b0;
            r_long_done    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_two          <= 1'b0;
            r_sel          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_addr))
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                    CFG_CLICK:    r_click    <= i_cfg_data;
                    CFG_LONG:     r_long     <= i_cfg_data;
                    CFG_ID:       r_id       <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
                r_in_raw   <= i_s_tdata[0];
                r_in_now   <= TIME_BITS'(i_s_tdata[InBits:1]);
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_noisy        <= n_noisy;
                r_deb          <= n_deb;
                r_change_time  <= n_change_time;
                r_press_time   <= n_press_time;
                r_long_ongoing <= n_long_ongoing;
                r_long_done    <= n_long_done;
                r_out_valid    <= (n_count != 2'd0);
                r_two          <= (n_count == 2'd2);
                r_sel          <= 1'b0;
                r_code0        <= n_code0;
                r_code1        <= n_code1;
                r_out_id       <= r_id;
                r_out_level    <= n_deb;
            end else if (r_out_valid && i_m_tready) begin
                if (o_m_tlast) begin
                    r_out_valid <= 1'b0;
                    r_sel       <= 1'b0;
                end else begin
                    r_sel <= 1'b1;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = !r_two || r_sel;
    assign o_m_tdata  = {4'b0000, r_out_level, r_out_id, r_sel ? r_code1 : r_code0};

`ifndef NO_ASSERTIONS
    a_sel_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_two && r_out_valid))
        else $error("second event selected without a pair");

    a_long_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_long_ongoing && r_long_done))
        else $error("long press ongoing and done at once");

    a_released_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_deb |-> (!r_long_ongoing && !r_long_done))
        else $error("long-press flag set while released");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("poll dropped while output register busy");
`endif

endmodule

>>> tb/sv/button_debounce_press_classifier_core_test.sv
`timescale 1ns / 1ps

module button_debounce_press_classifier_core_test
    import bdpc_pkg::*;
();

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned SettleCycles = 6;
    localparam int unsigned HoldCycles  = 400;
    localparam int unsigned PhasePolls  = 80;
    localparam int unsigned TotalPolls  = 650;

    typedef struct packed {
        logic [31:0] now;
        logic        raw;
    } t_poll;

    typedef struct packed {
        t_event_code        code;
        logic signed [15:0] id;
        logic               stable;
        logic               last;
    } t_press_event;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_addr = 2'd0;
    logic [CfgWidth-1:0] i_cfg_data = '0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [39:0]         i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [23:0]         o_m_tdata;
    logic                o_m_tlast;

    button_debounce_press_classifier_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // predictor copy of configuration and debounce state
    logic [15:0]        cfg_debounce = DebounceReset;
    logic [15:0]        cfg_click    = ClickReset;
    logic [15:0]        cfg_long     = LongReset;
    logic signed [15:0] cfg_id       = IdReset;
    logic               noisy_lvl  = 1'b0;
    logic               stable_lvl = 1'b0;
    logic [31:0]        noisy_t    = '0;
    logic [31:0]        press_t    = '0;
    logic               lp_active  = 1'b0;
    logic               lp_done    = 1'b0;

    t_poll        poll_q[$];
    t_press_event events_due[$];

    int unsigned polls_pushed   = 0;
    int unsigned polls_offered  = 0;
    int unsigned polls_accepted = 0;
    int unsigned events_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned code_seen[6]   = '{default: 0};
    int unsigned src_idle_pct   = 24;
    int unsigned snk_idle_pct   = 24;
    int unsigned holds_requested = 0;
    int unsigned holds_served   = 0;
    int unsigned snk_hold_left  = 0;
    logic [31:0] t_now          = '0;

    function automatic void classify_poll(logic raw, logic [31:0] now);
        t_event_code codes[2];
        int          n;
        logic        flipped;
        logic [31:0] since;
        t_press_event ev;
        n = 0;
        flipped = 1'b0;
        if (raw != noisy_lvl) begin
            noisy_lvl = raw;
            noisy_t = now;
        end
        since = now - noisy_t;
        if (since > {16'd0, cfg_debounce} && noisy_lvl != stable_lvl) begin
            stable_lvl = noisy_lvl;
            flipped = 1'b1;
        end
        if (flipped) begin
            if (stable_lvl) begin
                press_t = now;
                codes[n] = EV_PRESS;
                n = n + 1;
            end else begin
                codes[n] = EV_RELEASE;
                n = n + 1;
                if (lp_done) begin
                    lp_done = 1'b0;
                end else if (lp_active) begin
                    lp_active = 1'b0;
                    codes[n] = EV_LINTR;
                    n = n + 1;
                end else begin
                    codes[n] = EV_CLICK;
                    n = n + 1;
                end
            end
        end else if (stable_lvl && !lp_done) begin
            since = now - press_t;
            if (lp_active) begin
                if (since > {16'd0, cfg_long}) begin
                    lp_active = 1'b0;
                    lp_done = 1'b1;
                    codes[n] = EV_LFINISH;
                    n = n + 1;
                end
            end else if (since > {16'd0, cfg_click}) begin
                lp_active = 1'b1;
                codes[n] = EV_LSTART;
                n = n + 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            ev.code = codes[k];
            ev.id = cfg_id;
            ev.stable = stable_lvl;
            ev.last = (k == n - 1);
            events_due.push_back(ev);
        end
    endfunction

    // driver
    always @(negedge i_clk) begin : drive_polls
        t_poll nxt;
        if (!(i_s_tvalid && polls_accepted != polls_offered)) begin
            if (poll_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = poll_q.pop_front();
                i_s_tdata <= {7'd0, nxt};
                i_s_tvalid <= 1'b1;
                polls_offered++;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (holds_served != holds_requested) begin
            holds_served++;
            snk_hold_left <= HoldCycles;
            i_m_tready <= 1'b0;
        end else if (snk_hold_left > 0) begin
            snk_hold_left <= snk_hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch_events
        t_press_event want;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("button_debounce_press_classifier_core verification failed");
            $finish;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            polls_accepted++;
            classify_poll(i_s_tdata[0], i_s_tdata[32:1]);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (o_m_tdata[2:0] < 6) code_seen[o_m_tdata[2:0]]++;
            if (events_due.size() == 0) begin
                $error("unexpected event transaction, tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = events_due.pop_front();
                events_checked++;
                if (o_m_tdata[2:0] !== want.code) begin
                    $error("event_code expected %0d actual %0d", want.code, o_m_tdata[2:0]);
                    mismatches++;
                end
                if (o_m_tdata[18:3] !== want.id) begin
                    $error("event_id expected %0d actual %0d",
                           want.id, $signed(o_m_tdata[18:3]));
                    mismatches++;
                end
                if (o_m_tdata[19] !== want.stable) begin
                    $error("stable_level expected %0d actual %0d", want.stable, o_m_tdata[19]);
                    mismatches++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, o_m_tlast);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_poll(logic raw, logic [31:0] at);
        t_poll p;
        t_now = at;
        p.raw = raw;
        p.now = at;
        poll_q.push_back(p);
        polls_pushed++;
    endtask

    task automatic wait_quiet();
        while (poll_q.size() != 0 || polls_accepted != polls_offered || events_due.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_config(logic [15:0] deb, logic [15:0] clk_ms,
                                logic [15:0] lng, logic [15:0] id);
        logic [15:0] vals[4];
        vals = '{deb, clk_ms, lng, id};
        for (int r = CFG_DEBOUNCE; r <= CFG_ID; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= r[1:0];
            i_cfg_data <= vals[r];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_debounce = deb;
        cfg_click = clk_ms;
        cfg_long = lng;
        cfg_id = id;
    endtask

    // one press and release with bounce, glitches while held and random spacing
    task automatic push_press_cycle();
        int unsigned span;
        span = cfg_debounce;
        if (cfg_click > span) span = cfg_click;
        if (cfg_long > span) span = cfg_long;
        span = span / 3 + 2;
        repeat ($urandom_range(0, 3))
            push_poll(1'($urandom_range(0, 1)),
                      t_now + $urandom_range(0, cfg_debounce / 2 + 1));
        repeat ($urandom_range(2, 10))
            push_poll($urandom_range(0, 9) != 0, t_now + $urandom_range(0, span));
        repeat ($urandom_range(0, 3))
            push_poll(1'($urandom_range(0, 1)),
                      t_now + $urandom_range(0, cfg_debounce / 2 + 1));
        repeat ($urandom_range(2, 6))
            push_poll($urandom_range(0, 9) == 0, t_now + $urandom_range(0, span));
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned start_polls;
        phase = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bounce, strict compare, long press with raw low, release after
        // finished long press, click, long interrupt, timestamp wrap
        push_poll(1'b0, 32'd10);
        push_poll(1'b1, 32'd100);
        push_poll(1'b0, 32'd120);
        push_poll(1'b1, 32'd130);
        push_poll(1'b1, 32'd180);
        push_poll(1'b1, 32'd181);
        push_poll(1'b1, 32'd681);
        push_poll(1'b0, 32'd682);
        push_poll(1'b1, 32'd700);
        push_poll(1'b1, 32'd2182);
        push_poll(1'b1, 32'd5000);
        push_poll(1'b0, 32'd5001);
        push_poll(1'b0, 32'd5052);
        push_poll(1'b1, 32'd6000);
        push_poll(1'b1, 32'd6051);
        push_poll(1'b0, 32'd6100);
        push_poll(1'b0, 32'd6151);
        push_poll(1'b1, 32'd7000);
        push_poll(1'b1, 32'd7051);
        push_poll(1'b1, 32'd7600);
        push_poll(1'b0, 32'd7700);
        push_poll(1'b0, 32'd7751);
        push_poll(1'b1, 32'hFFFF_FFF0);
        push_poll(1'b1, 32'h0000_0030);
        push_poll(1'b0, 32'hFFFF_FFFF);
        push_poll(1'b0, 32'h0000_0040);
        wait_quiet();

        while (polls_pushed < TotalPolls) begin
            case (phase)
                0: write_config(16'd0, 16'd0, 16'd0, 16'h8000);
                1: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
                default: begin
                    if ($urandom_range(3) == 0)
                        write_config(16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom));
                    else
                        write_config(16'($urandom_range(0, 30)), 16'($urandom_range(0, 80)),
                                     16'($urandom_range(0, 200)), 16'($urandom));
                end
            endcase
            src_idle_pct = 24;
            snk_idle_pct = 24;
            if (phase == 2) begin
                src_idle_pct = 0;
                holds_requested++;
            end
            if (phase == 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            start_polls = polls_pushed;
            while (polls_pushed - start_polls < PhasePolls) begin
                if ($urandom_range(99) < 15) begin
                    repeat ($urandom_range(1, 3))
                        push_poll(1'($urandom_range(0, 1)), $urandom);
                end else begin
                    push_press_cycle();
                end
            end
            wait_quiet();
            phase++;
        end

        $display("%0d polls over %0d register settings, %0d events checked",
                 polls_accepted, phase + 1, events_checked);
        $display("press %0d release %0d click %0d long start %0d finish %0d interrupt %0d",
                 code_seen[EV_PRESS], code_seen[EV_RELEASE], code_seen[EV_CLICK],
                 code_seen[EV_LSTART], code_seen[EV_LFINISH], code_seen[EV_LINTR]);
        if (mismatches == 0) begin
            $display("button_debounce_press_classifier_core verification clean");
        end else begin
            $display("button_debounce_press_classifier_core verification failed");
        end
        $finish;
    end

endmodule
